/* rtl/marker_framed_sample_deframer_defines.svh */
// Assertion macros shared by the deframer checker.
`ifndef MARKER_FRAMED_SAMPLE_DEFRAMER_DEFINES_SVH
`define MARKER_FRAMED_SAMPLE_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DFR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dfr_pkg.sv */
// Shared types, constants and helpers of the marker framed sample deframer.
`timescale 1ns / 1ps
`default_nettype none

package dfr_pkg;

    localparam int MAX_CHANNELS_DEF = 10;

    localparam int BYTE_W      = 8;
    localparam int SAMPLE_W    = 13;
    localparam int INDEX_W     = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int COUNT_W     = 4;
    localparam int HIGH_SHIFT  = 5;
    localparam int MARKER_LEN  = 4;

    localparam logic [COUNT_W-1:0] RST_CHANNEL_COUNT = 4'd10;
    localparam logic [BYTE_W-1:0]  RST_MARKER0       = 8'd10;
    localparam logic [BYTE_W-1:0]  RST_MARKER1       = 8'd5;
    localparam logic [BYTE_W-1:0]  RST_MARKER2       = 8'd0;
    localparam logic [BYTE_W-1:0]  RST_MARKER3       = 8'd15;
    localparam logic [BYTE_W-1:0]  RST_START_BYTE    = 8'd240;
    localparam logic [BYTE_W-1:0]  RST_END_BYTE      = 8'd90;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NARROW_MODE   = 3'd0,
        CFG_CHANNEL_COUNT = 3'd1,
        CFG_MARKER0       = 3'd2,
        CFG_MARKER1       = 3'd3,
        CFG_MARKER2       = 3'd4,
        CFG_MARKER3       = 3'd5,
        CFG_START_BYTE    = 3'd6,
        CFG_END_BYTE      = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_SEARCH  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_CHECK   = 3'b100
    } phase_t;

    // Frame completion handed from the parser to the emitter.
    typedef struct packed {
        logic start;
        logic wide;
    } launch_t;

    // Wide samples overlap the two bytes: low | (high << 5).
    function automatic logic [SAMPLE_W-1:0] make_sample(
        input logic [BYTE_W-1:0] lo,
        input logic [BYTE_W-1:0] hi,
        input logic              wide
    );
        logic [SAMPLE_W-1:0] lo_ext;
        logic [SAMPLE_W-1:0] hi_ext;
        lo_ext = {{(SAMPLE_W-BYTE_W){1'b0}}, lo};
        hi_ext = {hi, {HIGH_SHIFT{1'b0}}};
        return wide ? (lo_ext | hi_ext) : lo_ext;
    endfunction

endpackage

`default_nettype wire

/* rtl/dfr_if.sv */
// Valid/ready channels for the byte stream and the decoded samples.
`timescale 1ns / 1ps
`default_nettype none

interface dfr_stream_if;
    logic                         valid;
    logic                         ready;
    logic [dfr_pkg::BYTE_W-1:0]   data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface dfr_sample_if;
    logic                          valid;
    logic                          ready;
    logic [dfr_pkg::SAMPLE_W-1:0]  sample;
    logic [dfr_pkg::INDEX_W-1:0]   channel_index;
    logic                          frame_last;

    modport source (output valid, output sample, output channel_index, output frame_last,
                    input ready);
    modport sink   (input valid, input sample, input channel_index, input frame_last,
                    output ready);
endinterface

`default_nettype wire

/* rtl/dfr_bank.sv */
// One payload bank: synchronous RAM with one write port and a registered read.
`timescale 1ns / 1ps
`default_nettype none

module dfr_bank #(
    parameter int DEPTH = dfr_pkg::MAX_CHANNELS_DEF,
    parameter int A_W   = 4
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [A_W-1:0]             waddr,
    input  wire logic [dfr_pkg::BYTE_W-1:0] wdata,
    input  wire logic                       re,
    input  wire logic [A_W-1:0]             raddr,
    output logic      [dfr_pkg::BYTE_W-1:0] rdata
);

    logic [dfr_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [dfr_pkg::BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/dfr_parser.sv */
// Configuration registers, marker search and payload capture into the banks.
`timescale 1ns / 1ps
`default_nettype none

module dfr_parser #(
    parameter int MAX_CHANNELS = dfr_pkg::MAX_CHANNELS_DEF,
    parameter int A_W          = 4,
    parameter int N_W          = 4
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [dfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    input  wire logic [dfr_pkg::BYTE_W-1:0]      in_data,
    output logic                                 in_ready,
    input  wire logic                            emit_busy,
    output logic                                 wr_en_lo,
    output logic                                 wr_en_hi,
    output logic      [A_W-1:0]                  wr_addr,
    output logic      [dfr_pkg::BYTE_W-1:0]      wr_data,
    output dfr_pkg::launch_t                     launch,
    output logic      [N_W-1:0]                  n_active
);

    localparam int POS_W = ($clog2(2 * MAX_CHANNELS) > 2) ? $clog2(2 * MAX_CHANNELS) : 2;

    logic                              narrow_reg;
    logic [dfr_pkg::COUNT_W-1:0]       count_reg;
    logic [dfr_pkg::BYTE_W-1:0]        mk0_reg, mk1_reg, mk2_reg, mk3_reg;
    logic [dfr_pkg::BYTE_W-1:0]        start_reg, end_reg;

    dfr_pkg::phase_t                   phase_reg, phase_next;
    logic [POS_W-1:0]                  pos_reg, pos_next;
    logic [31:0]                       window_reg, window_next;

    logic                              accept;
    logic                              hit;
    logic                              emit;
    logic                              mode_write;
    int                                pos_inc;
    int                                len;

    assign in_ready    = !emit_busy;
    assign accept      = in_valid && in_ready;
    assign window_next = {window_reg[23:0], in_data};
    assign hit         = (window_next == {mk0_reg, mk1_reg, mk2_reg, mk3_reg});
    assign pos_inc     = int'(pos_reg) + 1;
    assign len         = narrow_reg ? int'(n_active) : 2 * int'(n_active);
    assign mode_write  = cfg_we && (cfg_index == dfr_pkg::CFG_NARROW_MODE ||
                                    cfg_index == dfr_pkg::CFG_CHANNEL_COUNT);

    // Channel count of zero counts as one; above the bank depth it saturates.
    always_comb
    begin
        if (count_reg == '0)
        begin
            n_active = N_W'(1);
        end
        else if (int'(count_reg) > MAX_CHANNELS)
        begin
            n_active = N_W'(MAX_CHANNELS);
        end
        else
        begin
            n_active = N_W'(count_reg);
        end
    end

    // Wide payload bytes alternate between the low and high banks.
    always_comb
    begin
        wr_data  = in_data;
        wr_en_lo = 1'b0;
        wr_en_hi = 1'b0;
        wr_addr  = narrow_reg ? A_W'(pos_reg) : A_W'(pos_reg >> 1);
        if (accept && phase_reg == dfr_pkg::PH_PAYLOAD)
        begin
            wr_en_lo = narrow_reg || !pos_reg[0];
            wr_en_hi = !narrow_reg && pos_reg[0];
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        emit       = 1'b0;
        unique case (phase_reg)
            dfr_pkg::PH_PAYLOAD:
            begin
                pos_next = POS_W'(pos_inc);
                if (pos_inc >= len)
                begin
                    phase_next = dfr_pkg::PH_CHECK;
                    pos_next   = '0;
                end
            end
            dfr_pkg::PH_CHECK:
            begin
                if (!narrow_reg)
                begin
                    pos_next = POS_W'(pos_inc);
                    if (pos_inc >= dfr_pkg::MARKER_LEN)
                    begin
                        pos_next   = '0;
                        emit       = hit;
                        phase_next = hit ? dfr_pkg::PH_PAYLOAD : dfr_pkg::PH_SEARCH;
                    end
                end
                else
                begin
                    pos_next = '0;
                    if (in_data == end_reg)
                    begin
                        emit       = 1'b1;
                        phase_next = dfr_pkg::PH_SEARCH;
                    end
                    else if (in_data == start_reg)
                    begin
                        phase_next = dfr_pkg::PH_PAYLOAD;
                    end
                    else
                    begin
                        phase_next = dfr_pkg::PH_SEARCH;
                    end
                end
            end
            default:
            begin
                if (narrow_reg ? (in_data == start_reg) : hit)
                begin
                    phase_next = dfr_pkg::PH_PAYLOAD;
                    pos_next   = '0;
                end
            end
        endcase
    end

    assign launch.start = accept && emit;
    assign launch.wide  = !narrow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= dfr_pkg::PH_SEARCH;
            pos_reg    <= '0;
            window_reg <= '0;
        end
        else if (mode_write)
        begin
            phase_reg <= dfr_pkg::PH_SEARCH;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            window_reg <= window_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            narrow_reg <= 1'b0;
            count_reg  <= dfr_pkg::RST_CHANNEL_COUNT;
            mk0_reg    <= dfr_pkg::RST_MARKER0;
            mk1_reg    <= dfr_pkg::RST_MARKER1;
            mk2_reg    <= dfr_pkg::RST_MARKER2;
            mk3_reg    <= dfr_pkg::RST_MARKER3;
            start_reg  <= dfr_pkg::RST_START_BYTE;
            end_reg    <= dfr_pkg::RST_END_BYTE;
        end
        else if (cfg_we)
        begin
            unique case (dfr_pkg::cfg_idx_t'(cfg_index))
                dfr_pkg::CFG_NARROW_MODE:   narrow_reg <= cfg_data[0];
                dfr_pkg::CFG_CHANNEL_COUNT: count_reg  <= cfg_data[dfr_pkg::COUNT_W-1:0];
                dfr_pkg::CFG_MARKER0:       mk0_reg    <= cfg_data;
                dfr_pkg::CFG_MARKER1:       mk1_reg    <= cfg_data;
                dfr_pkg::CFG_MARKER2:       mk2_reg    <= cfg_data;
                dfr_pkg::CFG_MARKER3:       mk3_reg    <= cfg_data;
                dfr_pkg::CFG_START_BYTE:    start_reg  <= cfg_data;
                dfr_pkg::CFG_END_BYTE:      end_reg    <= cfg_data;
                default:                    narrow_reg <= narrow_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/dfr_emit.sv */
// Frame drain: reads both banks per channel and presents samples through an output register.
`timescale 1ns / 1ps
`default_nettype none

module dfr_emit #(
    parameter int A_W = 4,
    parameter int N_W = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dfr_pkg::launch_t              launch,
    input  wire logic [N_W-1:0]                n_active,
    output logic                               busy,
    output logic                               rd_en,
    output logic      [A_W-1:0]                rd_addr,
    input  wire logic [dfr_pkg::BYTE_W-1:0]    rd_lo,
    input  wire logic [dfr_pkg::BYTE_W-1:0]    rd_hi,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [dfr_pkg::SAMPLE_W-1:0]  sample,
    output logic      [dfr_pkg::INDEX_W-1:0]   channel_index,
    output logic                               frame_last
);

    logic                            busy_reg;
    logic                            wide_reg;
    logic [N_W-1:0]                  n_reg;
    logic [A_W-1:0]                  k_reg;
    logic                            rd_valid_reg;
    logic [A_W-1:0]                  rd_idx_reg;
    logic                            rd_last_reg;
    logic                            out_valid_reg;
    logic [dfr_pkg::SAMPLE_W-1:0]    sample_reg;
    logic [dfr_pkg::INDEX_W-1:0]     index_reg;
    logic                            last_reg;

    logic                            rd_move;
    logic                            k_last;

    assign rd_move = rd_valid_reg && (!out_valid_reg || out_ready);
    assign rd_en   = busy_reg && (!rd_valid_reg || rd_move);
    assign rd_addr = k_reg;
    assign k_last  = (int'(k_reg) + 1 == int'(n_reg));
    assign busy    = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            if (launch.start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            else if (rd_en)
            begin
                busy_reg <= !k_last;
                k_reg    <= A_W'(int'(k_reg) + 1);
            end

            if (rd_en)
            begin
                rd_valid_reg <= 1'b1;
            end
            else if (rd_move)
            begin
                rd_valid_reg <= 1'b0;
            end

            if (rd_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (launch.start)
        begin
            wide_reg <= launch.wide;
            n_reg    <= n_active;
        end
        if (rd_en)
        begin
            rd_idx_reg  <= k_reg;
            rd_last_reg <= k_last;
        end
        if (rd_move)
        begin
            sample_reg <= dfr_pkg::make_sample(rd_lo, rd_hi, wide_reg);
            index_reg  <= dfr_pkg::INDEX_W'(rd_idx_reg);
            last_reg   <= rd_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample        = sample_reg;
    assign channel_index = index_reg;
    assign frame_last    = last_reg;

endmodule

`default_nettype wire

/* rtl/marker_framed_sample_deframer.sv */
// Top level of the marker framed sample deframer.
`timescale 1ns / 1ps
`default_nettype none

// The deframer takes one byte per request on the stream channel and hunts for
// frames: in wide mode a four-byte sync marker followed by a low and a high
// byte per channel (sample = low | high << 5), in narrow mode a start byte,
// one byte per channel and an end byte. A frame's samples are released only
// once the next marker (wide) or the end byte (narrow) follows the payload
// directly; any mismatch sends the parser back to marker search, but in narrow
// mode a start byte in place of the end byte begins a new payload. While
// parsing and not held off, a byte is accepted every cycle. The byte that
// completes a frame starts a drain of n samples (n the active channel count):
// the payload sits in two single-port-read RAM banks, even and odd bytes in
// wide mode, read once per channel, and the stream is held off until the last
// bank read has been issued. The drain stalls while the receiver holds off a
// full output register and read stage. The banks need no clearing pass after
// reset, since a frame is never released before its payload has been written.
// Configuration is written through cfg_we, cfg_index and cfg_data; writes to
// the mode or channel count restart the marker search, marker writes apply to
// the next byte. Configuration should only be written while no frame is
// draining.
module marker_framed_sample_deframer #(
    parameter int MAX_CHANNELS = dfr_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    dfr_stream_if.sink                           stream,
    dfr_sample_if.source                         samples,
    input  wire logic                            cfg_we,
    input  wire logic [dfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dfr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Bank address has one entry per channel; the active count must hold MAX_CHANNELS.
    localparam int A_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int N_W = $clog2(MAX_CHANNELS + 1);

    logic                          emit_busy;
    logic                          wr_en_lo;
    logic                          wr_en_hi;
    logic [A_W-1:0]                wr_addr;
    logic [dfr_pkg::BYTE_W-1:0]    wr_data;
    dfr_pkg::launch_t              launch;
    logic [N_W-1:0]                n_active;
    logic                          rd_en;
    logic [A_W-1:0]                rd_addr;
    logic [dfr_pkg::BYTE_W-1:0]    rd_lo;
    logic [dfr_pkg::BYTE_W-1:0]    rd_hi;

    // The parser writes the banks only on accepted bytes, and bytes are only
    // accepted while the emitter issues no reads, so a write never meets a
    // read of the same frame.
    dfr_parser #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .A_W          (A_W),
        .N_W          (N_W)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (stream.valid),
        .in_data   (stream.data_byte),
        .in_ready  (stream.ready),
        .emit_busy (emit_busy),
        .wr_en_lo  (wr_en_lo),
        .wr_en_hi  (wr_en_hi),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .launch    (launch),
        .n_active  (n_active)
    );

    // Low bytes in wide mode and all bytes in narrow mode.
    dfr_bank #(
        .DEPTH (MAX_CHANNELS),
        .A_W   (A_W)
    ) u_bank_lo (
        .clk   (clk),
        .we    (wr_en_lo),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_lo)
    );

    // High bytes in wide mode.
    dfr_bank #(
        .DEPTH (MAX_CHANNELS),
        .A_W   (A_W)
    ) u_bank_hi (
        .clk   (clk),
        .we    (wr_en_hi),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_hi)
    );

    // The emitter keeps one sample in its read stage and one in its output
    // register, so the final samples may still wait while new bytes arrive.
    dfr_emit #(
        .A_W (A_W),
        .N_W (N_W)
    ) u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .launch        (launch),
        .n_active      (n_active),
        .busy          (emit_busy),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_lo         (rd_lo),
        .rd_hi         (rd_hi),
        .out_valid     (samples.valid),
        .out_ready     (samples.ready),
        .sample        (samples.sample),
        .channel_index (samples.channel_index),
        .frame_last    (samples.frame_last)
    );

endmodule

`default_nettype wire

/* rtl/dfr_checker.sv */
// Port-level checks on the deframer's sample channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "marker_framed_sample_deframer_defines.svh"

module dfr_checker #(
    parameter int MAX_CHANNELS = dfr_pkg::MAX_CHANNELS_DEF
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [dfr_pkg::SAMPLE_W-1:0]  sample,
    input wire logic [dfr_pkg::INDEX_W-1:0]   channel_index,
    input wire logic                          frame_last
);

    logic out_acc;

    assign out_acc = out_valid && out_ready;

    // A stalled sample request stays up and unchanged.
    `DFR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(sample) && $stable(channel_index) && $stable(frame_last), "sample request changed while stalled")

    // Channel positions stay within the bank depth.
    `DFR_ASSERT_SAME(a_index_range, clk, rst_n, out_valid, (MAX_CHANNELS > 16) || (int'(channel_index) < MAX_CHANNELS), "channel index beyond channel limit")

    // A non-last sample is never directly followed by one of the same channel.
    `DFR_ASSERT_NEXT(a_no_repeat, clk, rst_n, out_acc && !frame_last, !(out_acc && channel_index == $past(channel_index)), "channel index repeated within frame")

endmodule

bind marker_framed_sample_deframer dfr_checker #(
    .MAX_CHANNELS (MAX_CHANNELS)
) u_dfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (samples.valid),
    .out_ready     (samples.ready),
    .sample        (samples.sample),
    .channel_index (samples.channel_index),
    .frame_last    (samples.frame_last)
);

`default_nettype wire
